[rtl/core/tpc_pkg.sv]
// ----------------------------------------------------------------------------
// tpc_pkg: shared types and constants of the timer prescaler calculator
// Field widths, the prescaler shift table and the sideband and result structs.
// ----------------------------------------------------------------------------
package tpc_pkg;

  localparam int FRAC_W    = 8;   // fraction bits of the frequency format
  localparam int FREQ_W    = 40;
  localparam int CLK_W     = 30;
  localparam int TB_W      = 6;
  localparam int CODE_W    = 3;
  localparam int CMP_W     = 32;
  localparam int RF_W      = 40;
  localparam int PER_W     = 48;
  localparam int PER_FRAC  = 16;
  localparam int SUM_W     = FREQ_W + 1;
  localparam int PROD_W    = 42;
  localparam int MS_PER_S  = 1000;
  localparam int NUM_PRESC = 7;

  // Restoring divider geometry: dividend and divisor widths.
  localparam int DIV_NW = 60;
  localparam int DIV_DW = 41;

  // The prescalers are all powers of two: 1, 8, 32, 64, 128, 256, 1024.
  localparam logic [3:0] PRESC_SH [NUM_PRESC] = '{4'd0, 4'd3, 4'd5, 4'd6, 4'd7, 4'd8, 4'd10};
  localparam logic [CODE_W-1:0] CODE_LAST = CODE_W'(NUM_PRESC - 1);

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_LOW  = 2'd1,
    ST_HIGH = 2'd2
  } status_e;

  typedef enum logic {
    CFG_CLOCK = 1'b0,
    CFG_BITS  = 1'b1
  } cfg_reg_e;

  // Sideband that travels next to a divider.
  typedef struct packed {
    status_e               status;
    logic [CODE_W-1:0]     code;
    logic [CMP_W-1:0]      cmp;
    logic [CLK_W-1:0]      q;
    logic                  fz;
  } side_t;

  typedef struct packed {
    status_e               status;
    logic [CODE_W-1:0]     code;
    logic [CMP_W-1:0]      cmp;
    logic [RF_W-1:0]       rf;
    logic [PER_W-1:0]      per;
  } res_t;

endpackage

[rtl/core/timer_prescaler_compare_calc.sv]
// ----------------------------------------------------------------------------
// timer_prescaler_compare_calc: CTC timer prescaler and compare calculator
// For a wanted frequency, picks the prescaler and compare value of a timer.
// ----------------------------------------------------------------------------
// Usage. A request beat carries requested_freq_i (hertz, 8 fraction bits) and
// is taken at a clock edge where in_valid_i is high and in_stall_o is low. One
// result beat (status, prescaler code, compare value, reached frequency and
// period in ms as Q32.16) leaves on the output channel for every request, in
// order, taken where out_valid_o is high and out_stall_i is low.
// The CPU clock and timer width registers are written through cfg_we_i,
// cfg_idx_i and cfg_data_i; the user must write them only while no request
// is in flight, which the block itself does not enforce. Throughput is one
// beat per cycle while the skid register is empty. A request passes through
// 128 registers, the first loaded at the accepting edge: three stages of
// range check and prescaler choice, a 61-stage divider for the compare value,
// two stages that saturate it and scale it by 1000, a second pair of 61-stage
// dividers for the reached frequency and the period, and the output register.
// When the receiver stalls, the output register holds its beat and one more
// beat drops into a skid register; while the skid register is full the whole
// pipeline freezes and in_stall_o is high. Nothing is lost or repeated.
// Reset empties the pipeline and loads a 16 MHz clock and an 8-bit timer.
// ----------------------------------------------------------------------------
module timer_prescaler_compare_calc (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [tpc_pkg::FREQ_W-1:0]  requested_freq_i,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [tpc_pkg::CLK_W-1:0]   cfg_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  status_o,
  output logic [tpc_pkg::CODE_W-1:0]  prescaler_code_o,
  output logic [tpc_pkg::CMP_W-1:0]   compare_value_o,
  output logic [tpc_pkg::RF_W-1:0]    real_freq_o,
  output logic [tpc_pkg::PER_W-1:0]   real_period_ms_o
);
  import tpc_pkg::*;

  // Configuration registers.
  logic [CLK_W-1:0] cpu_clock_hz_q;
  logic [TB_W-1:0]  timer_bits_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cpu_clock_hz_q <= CLK_W'(16000000);
      timer_bits_q   <= TB_W'(8);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        CFG_CLOCK: cpu_clock_hz_q <= cfg_data_i;
        CFG_BITS:  timer_bits_q   <= cfg_data_i[TB_W-1:0];
        default:   ;
      endcase
    end
  end

  // The whole pipeline advances together unless the skid register is full.
  logic en;
  logic skid_vld_q, out_vld_q;
  res_t skid_q, out_q;

  assign en         = !skid_vld_q;
  assign in_stall_o = skid_vld_q;

  // Range check and prescaler choice.
  logic              sel_vld;
  logic [FREQ_W-1:0] sel_freq;
  side_t             sel_side;

  tpc_select u_select (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .vld_i    (in_valid_i),
    .freq_i   (requested_freq_i),
    .clk_hz_i (cpu_clock_hz_q),
    .tbits_i  (timer_bits_q),
    .vld_o    (sel_vld),
    .freq_o   (sel_freq),
    .side_o   (sel_side)
  );

  // Compare value: (2 * q * 256 + f) / (2 * f).
  logic [DIV_NW-1:0] num1;
  logic [DIV_DW-1:0] den1;
  logic              d1_vld;
  logic [DIV_NW-1:0] d1_quo;
  side_t             d1_side;

  assign num1 = (DIV_NW'(sel_side.q) << (FRAC_W + 1)) + DIV_NW'(sel_freq);
  assign den1 = DIV_DW'(sel_freq) << 1;

  tpc_div u_div_cmp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (sel_vld),
    .num_i  (num1),
    .den_i  (den1),
    .side_i (sel_side),
    .vld_o  (d1_vld),
    .quo_o  (d1_quo),
    .side_o (d1_side)
  );

  // Saturate the compare value, then scale it by 1000 for the period.
  side_t              a_side_d, a_side_q, b_side_q;
  logic               a_vld_q, b_vld_q;
  logic [PROD_W-1:0]  prod_q;

  always_comb begin
    a_side_d = d1_side;
    if (d1_side.status != ST_OK) begin
      a_side_d.cmp = '0;
    end else if (d1_side.fz) begin
      a_side_d.cmp = (d1_side.q != '0) ? '1 : '0;
    end else if (|d1_quo[DIV_NW-1:CMP_W]) begin
      a_side_d.cmp = '1;
    end else begin
      a_side_d.cmp = d1_quo[CMP_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      b_vld_q <= 1'b0;
    end else if (en) begin
      a_vld_q <= d1_vld;
      b_vld_q <= a_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_side_q <= a_side_d;
      b_side_q <= a_side_q;
      prod_q   <= PROD_W'(a_side_q.cmp) * PROD_W'(MS_PER_S);
    end
  end

  // Reached frequency: (2 * q * 256 + cmp) / (2 * cmp).
  // Period: (2 * cmp * 1000 * 2^16 + q) / (2 * q).
  logic [DIV_NW-1:0] num2, num3, d2_quo, d3_quo;
  logic [DIV_DW-1:0] den2, den3;
  logic              d2_vld, d3_vld;
  side_t             d2_side, d3_side;

  assign num2 = (DIV_NW'(b_side_q.q) << (FRAC_W + 1)) + DIV_NW'(b_side_q.cmp);
  assign den2 = DIV_DW'(b_side_q.cmp) << 1;
  assign num3 = (DIV_NW'(prod_q) << (PER_FRAC + 1)) + DIV_NW'(b_side_q.q);
  assign den3 = DIV_DW'(b_side_q.q) << 1;

  tpc_div u_div_freq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (b_vld_q),
    .num_i  (num2),
    .den_i  (den2),
    .side_i (b_side_q),
    .vld_o  (d2_vld),
    .quo_o  (d2_quo),
    .side_o (d2_side)
  );

  tpc_div u_div_per (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (b_vld_q),
    .num_i  (num3),
    .den_i  (den3),
    .side_i (b_side_q),
    .vld_o  (d3_vld),
    .quo_o  (d3_quo),
    .side_o (d3_side)
  );

  // Special cases and the final assembly of the result beat.
  res_t res;

  always_comb begin
    res.status = d3_side.status;
    res.code   = d2_side.code;
    res.cmp    = d2_side.cmp;
    if (d2_side.cmp == '0) begin
      res.rf = (d2_side.q != '0) ? '1 : '0;
    end else begin
      res.rf = d2_quo[RF_W-1:0];
    end
    if (d2_side.q == '0) begin
      res.per = '1;
    end else if (|d3_quo[DIV_NW-1:PER_W]) begin
      res.per = '1;
    end else begin
      res.per = d3_quo[PER_W-1:0];
    end
    if (d3_side.status != ST_OK) begin
      res.code = '0;
      res.cmp  = '0;
      res.rf   = '0;
      res.per  = '0;
    end
  end

  // Output register with a skid register behind it.
  logic out_take;
  assign out_take = out_vld_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (out_take) begin
        skid_vld_q <= 1'b0;
      end
    end else if (!out_vld_q || out_take) begin
      out_vld_q <= d2_vld;
    end else if (d2_vld) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (!out_vld_q || out_take) begin
      out_q <= res;
    end else begin
      skid_q <= res;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign status_o         = out_q.status;
  assign prescaler_code_o = out_q.code;
  assign compare_value_o  = out_q.cmp;
  assign real_freq_o      = out_q.rf;
  assign real_period_ms_o = out_q.per;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid register full while output register empty");

  a_skid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q && !out_take |=> skid_vld_q)
    else $error("skid beat dropped without being taken");

  a_div_lockstep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    d2_vld == d3_vld)
    else $error("frequency and period dividers out of step");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.status != ST_OK |-> out_q.cmp == '0 && out_q.code == '0)
    else $error("error result carries a nonzero compare value");

  a_code_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> out_q.code <= CODE_LAST)
    else $error("prescaler code out of range");
`endif

endmodule

[rtl/core/tpc_select.sv]
// ----------------------------------------------------------------------------
// tpc_select: range check and prescaler choice
// Three register stages: threshold sums, scaling by the timer width, compare.
// ----------------------------------------------------------------------------
module tpc_select (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         en_i,
  input  logic                         vld_i,
  input  logic [tpc_pkg::FREQ_W-1:0]   freq_i,
  input  logic [tpc_pkg::CLK_W-1:0]    clk_hz_i,
  input  logic [tpc_pkg::TB_W-1:0]     tbits_i,
  output logic                         vld_o,
  output logic [tpc_pkg::FREQ_W-1:0]   freq_o,
  output tpc_pkg::side_t               side_o
);
  import tpc_pkg::*;

  // f * (2^tb - 1) < r  is the same as  f < ceil((r + f) / 2^tb).
  logic [SUM_W-1:0]  s_q [NUM_PRESC];
  logic [SUM_W-1:0]  c_d [NUM_PRESC];
  logic [SUM_W-1:0]  c_q [NUM_PRESC];
  logic [FREQ_W-1:0] f1_q, f2_q;
  logic [CLK_W-1:0]  clk1_q, clk2_q;
  logic [TB_W-1:0]   tb1_q;
  logic [2:0]        vld_q;
  logic [NUM_PRESC-1:0] lt;
  side_t             side_d, side_q;
  logic [FREQ_W-1:0] f3_q;

  always_comb begin
    for (int i = 0; i < NUM_PRESC; i++) begin
      c_d[i] = (s_q[i] >> tb1_q)
             + SUM_W'(|(s_q[i] & ~({SUM_W{1'b1}} << tb1_q)));
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_PRESC; i++) begin
      lt[i] = {1'b0, f2_q} < c_q[i];
    end
    side_d        = '0;
    side_d.fz     = (f2_q == '0);
    side_d.code   = CODE_LAST;
    for (int i = NUM_PRESC - 2; i >= 0; i--) begin
      if (!lt[i]) begin
        side_d.code = CODE_W'(i);
      end
    end
    if (lt[NUM_PRESC-1]) begin
      side_d.status = ST_LOW;
    end else if ({1'b0, f2_q} > (SUM_W'(clk2_q) << FRAC_W)) begin
      side_d.status = ST_HIGH;
    end else begin
      side_d.status = ST_OK;
    end
    side_d.q = clk2_q >> PRESC_SH[side_d.code];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < NUM_PRESC; i++) begin
        s_q[i] <= (SUM_W'(clk_hz_i >> PRESC_SH[i]) << FRAC_W) + SUM_W'(freq_i);
        c_q[i] <= c_d[i];
      end
      f1_q   <= freq_i;
      clk1_q <= clk_hz_i;
      tb1_q  <= tbits_i;
      f2_q   <= f1_q;
      clk2_q <= clk1_q;
      side_q <= side_d;
      f3_q   <= f2_q;
    end
  end

  assign vld_o  = vld_q[2];
  assign side_o = side_q;
  assign freq_o = f3_q;

endmodule

[rtl/core/tpc_div.sv]
// ----------------------------------------------------------------------------
// tpc_div: pipelined restoring divider
// An input register, then one quotient bit per stage, sideband carried along.
// ----------------------------------------------------------------------------
module tpc_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        vld_i,
  input  logic [tpc_pkg::DIV_NW-1:0]  num_i,
  input  logic [tpc_pkg::DIV_DW-1:0]  den_i,
  input  tpc_pkg::side_t              side_i,
  output logic                        vld_o,
  output logic [tpc_pkg::DIV_NW-1:0]  quo_o,
  output tpc_pkg::side_t              side_o
);
  import tpc_pkg::*;

  localparam int AW = DIV_NW + DIV_DW;

  // Upper DIV_DW bits hold the partial remainder, the lower bits the
  // dividend bits still to come and the quotient bits already found.
  logic [AW-1:0]     acc_q  [DIV_NW+1];
  logic [DIV_DW-1:0] den_q  [DIV_NW+1];
  side_t             side_q [DIV_NW+1];
  logic [DIV_NW:0]   vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[DIV_NW-1:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      acc_q[0]  <= AW'(num_i);
      den_q[0]  <= den_i;
      side_q[0] <= side_i;
    end
  end

  for (genvar k = 1; k <= DIV_NW; k++) begin : g_step
    logic [AW:0]       sh;
    logic [DIV_DW:0]   diff;
    logic [AW-1:0]     acc_d;

    always_comb begin
      sh   = {acc_q[k-1], 1'b0};
      diff = sh[AW:DIV_NW] - {1'b0, den_q[k-1]};
      if (!diff[DIV_DW]) begin
        acc_d = {diff[DIV_DW-1:0], sh[DIV_NW-1:1], 1'b1};
      end else begin
        acc_d = {sh[AW-1:DIV_NW], sh[DIV_NW-1:0]};
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        acc_q[k]  <= acc_d;
        den_q[k]  <= den_q[k-1];
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign vld_o  = vld_q[DIV_NW];
  assign quo_o  = acc_q[DIV_NW][DIV_NW-1:0];
  assign side_o = side_q[DIV_NW];

endmodule
